[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the Hill cipher block encrypt unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on the rising clock edge and switched off
// while the active-low reset is held.
`define HCB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is checked on every rising edge, reset included.
`define HCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/hcb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Types and constants shared by the Hill cipher block encrypt unit.
// ----------------------------------------------------------------------------
package hcb_pkg;

  // Field widths
  localparam int LETTER_W    = 5;
  localparam int KEY_W       = 5;
  localparam int SIZE_W      = 4;
  localparam int TDATA_W     = 8;

  // Key layout: 64 entries of five bits, row stride of eight entries
  localparam int KEY_STRIDE  = 8;
  localparam int KEY_ENTRIES = 64;
  localparam int KEY_BITS    = KEY_ENTRIES * KEY_W;
  localparam int KEY_ROW_W   = KEY_STRIDE * KEY_W;

  // Configuration port
  localparam int CFG_DATA_W  = 60;
  localparam int KEY_PACKS   = 5;
  localparam int KEY_PACK5_W = 20;
  localparam int CFG_IDX_W   = 3;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = 4'd2;

  // Alphabet and padding
  localparam int ALPHABET    = 26;
  localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

  // Reciprocal of the alphabet size, scaled by two to the sixteen and rounded
  // down, so the estimated quotient is at most one below the true quotient.
  localparam int RECIP       = 2520;
  localparam int RECIP_W     = 12;
  localparam int RECIP_SHIFT = 16;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE = 3'd0,
    REG_KEY_PACK_0 = 3'd1,
    REG_KEY_PACK_1 = 3'd2,
    REG_KEY_PACK_2 = 3'd3,
    REG_KEY_PACK_3 = 3'd4,
    REG_KEY_PACK_4 = 3'd5,
    REG_KEY_PACK_5 = 3'd6
  } hcb_cfg_reg_t;

  // Block header that travels with a collected block
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              msg_end;
  } hcb_blk_hdr_t;

  localparam int HDR_W = SIZE_W + 1;

  // One cipher letter with its markers
  typedef struct packed {
    logic [LETTER_W-1:0] code;
    logic                block_last;
    logic                message_last;
  } hcb_res_t;

endpackage

[hdl/hcb_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_queue
// Short first-in first-out queue of collected blocks between the front and
// the back of the encryptor.
// ----------------------------------------------------------------------------
module hcb_queue #(
  parameter int DATA_W = 45,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rptr_r];

  // Pointer and fill level update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

[hdl/hcb_front.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// hcb_front
// Collects plaintext letters into a block, pads it with X when it closes and
// hands the finished block to the queue.
// ----------------------------------------------------------------------------
module hcb_front
  import hcb_pkg::*;
#(
  parameter int MAX_BLOCK = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [LETTER_W-1:0]                 in_letter,
  input  logic                                in_end,
  input  logic [SIZE_W-1:0]                   size_act,
  input  logic                                q_ready,
  output logic                                q_push,
  output logic [HDR_W+MAX_BLOCK*LETTER_W-1:0] q_data
);

  logic [LETTER_W-1:0]                   buf_r [MAX_BLOCK];
  logic [SIZE_W-1:0]                     fill_count_r, fill_count_nxt;
  logic [SIZE_W-1:0]                     fill_inc;
  logic                                  accept;
  logic                                  blk_done;
  logic [MAX_BLOCK-1:0][LETTER_W-1:0]    vec;
  hcb_blk_hdr_t                          hdr;

  // Every transfer either fills a slot or closes a block, so the front only
  // waits for room in the queue.
  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign fill_inc = fill_count_r + SIZE_W'(1);
  assign blk_done = (fill_inc >= size_act) || in_end;
  assign q_push   = accept && blk_done;

  // Padded block: held letters, then the arriving letter, then X up to the
  // block size, and zero beyond it.
  always_comb begin
    for (int j = 0; j < MAX_BLOCK; j++) begin
      if (SIZE_W'(j) >= size_act) begin
        vec[j] = '0;
      end else if (SIZE_W'(j) == fill_count_r) begin
        vec[j] = in_letter;
      end else if (SIZE_W'(j) < fill_inc) begin
        vec[j] = buf_r[j];
      end else begin
        vec[j] = PAD_LETTER;
      end
    end
  end

  assign hdr.size    = size_act;
  assign hdr.msg_end = in_end;
  assign q_data      = {hdr, vec};

  // Fill level
  always_comb begin
    fill_count_nxt = fill_count_r;
    if (accept) begin
      fill_count_nxt = blk_done ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
    end else begin
      fill_count_r <= fill_count_nxt;
    end
  end

  // Letter buffer, written at the current fill position
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_BLOCK; j++) begin
      if (accept && (SIZE_W'(j) == fill_count_r)) begin
        buf_r[j] <= in_letter;
      end
    end
  end

  `HCB_ASSERT(a_fill_in_range, clk, rst_n, fill_count_r < SIZE_W'(MAX_BLOCK), "fill level out of range")
  `HCB_ASSERT(a_push_clears_fill, clk, rst_n, q_push |=> (fill_count_r == '0), "fill not cleared after block")
  `HCB_ASSERT(a_fill_steps, clk, rst_n, (accept && !q_push) |=> (fill_count_r == $past(fill_count_r) + SIZE_W'(1)), "fill did not advance by one")

endmodule

[hdl/hcb_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// hcb_back
// Enciphers queued blocks one row per cycle when not stalled: dot product of
// a key row with the block, reduction mod 26, output register to the receiver.
// ----------------------------------------------------------------------------
module hcb_back
  import hcb_pkg::*;
#(
  parameter int MAX_BLOCK = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  logic [HDR_W+MAX_BLOCK*LETTER_W-1:0] q_data,
  output logic                                q_ready,
  input  logic [KEY_BITS-1:0]                 key_flat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output hcb_res_t                            out_res
);

  localparam int VEC_W   = MAX_BLOCK * LETTER_W;
  localparam int IDX_W   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int ACC_MAX = MAX_BLOCK * ((1 << KEY_W) - 1) * ((1 << LETTER_W) - 1);
  localparam int ACC_W   = $clog2(ACC_MAX + 1);
  localparam int Q_W     = ACC_W - 4;
  localparam int QP_W    = ACC_W + RECIP_W;
  localparam int PROD_W  = KEY_W + LETTER_W;

  // Block being enciphered
  logic                               busy_r, busy_nxt;
  logic [IDX_W-1:0]                   row_r, row_nxt;
  logic [MAX_BLOCK-1:0][LETTER_W-1:0] blk_r;
  hcb_blk_hdr_t                       hdr_r;
  hcb_blk_hdr_t                       q_hdr;

  // Pipeline registers
  logic              s1_valid_r, s2_valid_r, out_valid_r;
  logic [ACC_W-1:0]  s1_acc_r, s2_acc_r;
  logic [Q_W-1:0]    s2_q_r;
  logic              s1_blast_r, s1_mlast_r, s2_blast_r, s2_mlast_r;
  hcb_res_t          out_res_r;

  logic              adv;
  logic              last_row;
  logic              load;
  logic [KEY_ROW_W-1:0] key_row;
  logic [PROD_W-1:0] prod [MAX_BLOCK];
  logic [ACC_W-1:0]  acc_c;
  logic [QP_W-1:0]   qp_c;
  logic [ACC_W-1:0]  q_ext;
  logic [ACC_W-1:0]  rem_c;
  logic [LETTER_W-1:0] code_c;

  assign q_hdr = hcb_blk_hdr_t'(q_data[HDR_W+VEC_W-1 -: HDR_W]);

  // The whole pipeline moves when the output register is free or taken.
  assign adv      = !out_valid_r || out_ready;
  assign last_row = ((SIZE_W'(row_r) + SIZE_W'(1)) == hdr_r.size);
  assign load     = q_valid && (!busy_r || (adv && last_row));
  assign q_ready  = load;

  // Row sequencer
  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    if (load) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
    end else if (adv && busy_r) begin
      busy_nxt = !last_row;
      row_nxt  = row_r + IDX_W'(1);
    end
  end

  // Dot product of the current key row with the block
  assign key_row = key_flat[row_r*KEY_ROW_W +: KEY_ROW_W];

  always_comb begin
    acc_c = '0;
    for (int j = 0; j < MAX_BLOCK; j++) begin
      prod[j] = PROD_W'(key_row[j*KEY_W +: KEY_W]) * PROD_W'(blk_r[j]);
      acc_c   = acc_c + ACC_W'(prod[j]);
    end
  end

  // Quotient estimate by the scaled reciprocal
  assign qp_c = QP_W'(s1_acc_r) * QP_W'(RECIP);

  // Remainder: subtract 26 times the estimate, then correct once.
  assign q_ext  = ACC_W'(s2_q_r);
  assign rem_c  = s2_acc_r - ((q_ext << 4) + (q_ext << 3) + (q_ext << 1));
  assign code_c = (rem_c >= ACC_W'(ALPHABET)) ? LETTER_W'(rem_c - ACC_W'(ALPHABET))
                                             : LETTER_W'(rem_c);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      row_r  <= row_nxt;
      if (adv) begin
        s1_valid_r  <= busy_r;
        s2_valid_r  <= s1_valid_r;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      blk_r <= q_data[VEC_W-1:0];
      hdr_r <= q_hdr;
    end
    if (adv) begin
      s1_acc_r   <= acc_c;
      s1_blast_r <= last_row;
      s1_mlast_r <= last_row && hdr_r.msg_end;
      s2_acc_r   <= s1_acc_r;
      s2_q_r     <= qp_c[RECIP_SHIFT +: Q_W];
      s2_blast_r <= s1_blast_r;
      s2_mlast_r <= s1_mlast_r;
      out_res_r.code         <= code_c;
      out_res_r.block_last   <= s2_blast_r;
      out_res_r.message_last <= s2_mlast_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `HCB_ASSERT(a_row_in_block, clk, rst_n, busy_r |-> (SIZE_W'(row_r) < hdr_r.size), "row beyond block size")
  `HCB_ASSERT(a_pop_needs_block, clk, rst_n, q_ready |-> q_valid, "queue popped while empty")
  `HCB_ASSERT(a_msg_on_block_end, clk, rst_n, (out_valid_r && out_res_r.message_last) |-> out_res_r.block_last, "message end off block end")

endmodule

[hdl/hill_cipher_block_encrypt_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_block_encrypt_unit
// Hill cipher encryptor: collects letters into blocks and emits cipher rows.
// ----------------------------------------------------------------------------
// Plaintext letters (0..25) arrive on the in_ stream, one per transfer; tlast
// marks the final letter of a message. A block closes when block_size letters
// are held or on tlast; it is padded with X and moved to a two-block queue.
// The back end then emits block_size cipher letters on the out_ stream, one
// row per cycle; out_tlast marks the last letter of each block and out_tuser
// the last letter of a message.
// Throughput: one letter per cycle on the input as long as the queue has
// room; one cipher letter per cycle on the output, with no gap between
// blocks while the next is queued. The row engine sets the pace: one
// key-row dot product per cycle. A closed block reaches the output through
// the queue, row issue, sum, quotient estimate and reduction output registers.
// When the receiver holds out_tready low the whole back end waits; the front
// keeps taking letters until the queue holds two closed blocks.
// Reset clears the fill level, the queue and the pipeline, sets block_size to
// two and the key to zero. Configuration writes are taken on any cycle with
// cfg_we high and must only be made while the unit is idle.
// ----------------------------------------------------------------------------
module hill_cipher_block_encrypt_unit
  import hcb_pkg::*;
#(
  parameter int MAX_BLOCK = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Plaintext stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // [4:0] letter_code, [7:5] zero
  input  logic                  in_tlast,   // message_end
  // Cipher stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // [4:0] cipher_code, [7:5] zero
  output logic                  out_tlast,  // block_last
  output logic                  out_tuser,  // message_last
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int Q_DATA_W = HDR_W + MAX_BLOCK * LETTER_W;

  logic [SIZE_W-1:0]      block_size_r;
  logic [CFG_DATA_W-1:0]  key_pack_r [KEY_PACKS];
  logic [KEY_PACK5_W-1:0] key_pack5_r;
  logic [SIZE_W-1:0]      size_act;
  logic [KEY_BITS-1:0]    key_flat;

  logic                   q_push;
  logic                   q_full;
  logic [Q_DATA_W-1:0]    q_push_data;
  logic                   q_pop;
  logic                   q_valid;
  logic [Q_DATA_W-1:0]    q_pop_data;
  hcb_res_t               res;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLOCK_SIZE_RESET;
      for (int k = 0; k < KEY_PACKS; k++) begin
        key_pack_r[k] <= '0;
      end
      key_pack5_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SIZE: block_size_r  <= cfg_wdata[SIZE_W-1:0];
        REG_KEY_PACK_0: key_pack_r[0] <= cfg_wdata;
        REG_KEY_PACK_1: key_pack_r[1] <= cfg_wdata;
        REG_KEY_PACK_2: key_pack_r[2] <= cfg_wdata;
        REG_KEY_PACK_3: key_pack_r[3] <= cfg_wdata;
        REG_KEY_PACK_4: key_pack_r[4] <= cfg_wdata;
        REG_KEY_PACK_5: key_pack5_r   <= cfg_wdata[KEY_PACK5_W-1:0];
        default: ;
      endcase
    end
  end

  // Block size in use: zero counts as one, and it is capped at the maximum.
  always_comb begin
    if (block_size_r == '0) begin
      size_act = SIZE_W'(1);
    end else if (block_size_r > SIZE_W'(MAX_BLOCK)) begin
      size_act = SIZE_W'(MAX_BLOCK);
    end else begin
      size_act = block_size_r;
    end
  end

  // All 64 key entries, entry e at bit 5*e
  assign key_flat = {key_pack5_r, key_pack_r[4], key_pack_r[3], key_pack_r[2],
                     key_pack_r[1], key_pack_r[0]};

  hcb_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_letter (in_tdata[LETTER_W-1:0]),
    .in_end    (in_tlast),
    .size_act  (size_act),
    .q_ready   (!q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  hcb_queue #(
    .DATA_W (Q_DATA_W),
    .DEPTH  (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_pop_data)
  );

  hcb_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_pop_data),
    .q_ready   (q_pop),
    .key_flat  (key_flat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {(TDATA_W - LETTER_W)'(0), res.code};
  assign out_tlast = res.block_last;
  assign out_tuser = res.message_last;

endmodule

[tb/sv/hcb_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_tb_pkg
// Cipher scoreboard for the Hill cipher block encrypt unit testbench.
// ----------------------------------------------------------------------------
// The scoreboard keeps its own copy of the block size, the packed key, the
// letter buffer and the fill level. Each letter transfer on the input side is
// folded into the buffer. When a block closes, the padded block is enciphered
// and the cipher letters are queued. Each cipher letter transfer on the output
// side is compared with the oldest queued letter.
// ----------------------------------------------------------------------------
package hcb_tb_pkg;

  import hcb_pkg::*;

  localparam int MAX_BLOCK        = 8;
  localparam int PACK_COUNT       = KEY_PACKS + 1;
  localparam int ENTRIES_PER_PACK = CFG_DATA_W / KEY_W;

  class cipher_scoreboard;

    logic [SIZE_W-1:0]     block_size;
    logic [CFG_DATA_W-1:0] key_pack [PACK_COUNT];
    logic [LETTER_W-1:0]   block_letters [MAX_BLOCK];
    logic [2:0]            fill_count;
    hcb_res_t              cipher_queue [$];
    int unsigned           errors;

    function new();
      block_size = BLOCK_SIZE_RESET;
      foreach (key_pack[k]) key_pack[k] = '0;
      foreach (block_letters[k]) block_letters[k] = '0;
      fill_count = '0;
      errors     = 0;
    endfunction

    // Mirror a configuration write; unknown indexes leave everything alone.
    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_BLOCK_SIZE: block_size = value[SIZE_W-1:0];
        REG_KEY_PACK_0, REG_KEY_PACK_1, REG_KEY_PACK_2,
        REG_KEY_PACK_3, REG_KEY_PACK_4: key_pack[index - REG_KEY_PACK_0] = value;
        REG_KEY_PACK_5: key_pack[KEY_PACKS] = CFG_DATA_W'(value[KEY_PACK5_W-1:0]);
        default: ;
      endcase
    endfunction

    // Key entry row*8+col, five bits from its packed word.
    function int unsigned key_entry(int unsigned row, int unsigned col);
      int unsigned           entry;
      logic [CFG_DATA_W-1:0] word;
      entry = (row * KEY_STRIDE + col) % KEY_ENTRIES;
      word  = key_pack[entry / ENTRIES_PER_PACK] >> (KEY_W * (entry % ENTRIES_PER_PACK));
      return word[KEY_W-1:0];
    endfunction

    // Fold one letter into the block; a closed block queues its cipher row letters.
    function void note_letter(logic [LETTER_W-1:0] letter, logic msg_end);
      int unsigned size;
      int unsigned fill;
      int unsigned acc;
      int unsigned plain;
      hcb_res_t    res;
      size = block_size;
      if (size == 0) size = 1;
      if (size > MAX_BLOCK) size = MAX_BLOCK;
      fill = fill_count;
      if (fill < MAX_BLOCK) block_letters[fill] = letter;
      fill++;
      if (fill < size && !msg_end) begin
        fill_count = fill[2:0];
        return;
      end
      // Unfilled positions are padded with X before the key is applied.
      for (int unsigned row = 0; row < size; row++) begin
        acc = 0;
        for (int unsigned col = 0; col < size; col++) begin
          plain = (col < fill) ? block_letters[col] : PAD_LETTER;
          acc += key_entry(row, col) * plain;
        end
        res.code         = LETTER_W'(acc % ALPHABET);
        res.block_last   = (row + 1 == size);
        res.message_last = msg_end && (row + 1 == size);
        cipher_queue.push_back(res);
      end
      fill_count = '0;
    endfunction

    // Compare one cipher letter transfer with the oldest expected letter.
    function void check_cipher(logic [TDATA_W-1:0] tdata, logic tlast, logic tuser);
      hcb_res_t want;
      if (cipher_queue.size() == 0) begin
        $error("cipher letter %0d arrived with no letter expected", tdata[LETTER_W-1:0]);
        errors++;
        return;
      end
      want = cipher_queue.pop_front();
      if (tdata[LETTER_W-1:0] !== want.code) begin
        $error("cipher_code: expected %0d, actual %0d", want.code, tdata[LETTER_W-1:0]);
        errors++;
      end
      if (tdata[TDATA_W-1:LETTER_W] !== '0) begin
        $error("tdata padding: expected 0, actual %0d", tdata[TDATA_W-1:LETTER_W]);
        errors++;
      end
      if (tlast !== want.block_last) begin
        $error("block_last: expected %0b, actual %0b", want.block_last, tlast);
        errors++;
      end
      if (tuser !== want.message_last) begin
        $error("message_last: expected %0b, actual %0b", want.message_last, tuser);
        errors++;
      end
    endfunction

    function int unsigned expected_count();
      return cipher_queue.size();
    endfunction

  endclass

endpackage

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for hill_cipher_block_encrypt_unit.
// ----------------------------------------------------------------------------
// A directed part covers the reset key, block sizes of zero (as one), eight and
// above eight, an all-ones key, letter codes above Z, flushes on the end of a
// message and a block size lowered while a block is part filled. A random part
// then runs several configuration phases with random letters and message ends.
// Both streams idle at random, except in one quiet phase, and the sender once
// holds off mid-phase until every cipher letter has arrived. A scoreboard
// predicts each cipher letter and checks the output transfers in order.
// ----------------------------------------------------------------------------
module testbench;

  import hcb_pkg::*;
  import hcb_tb_pkg::*;

  localparam real         CLK_PERIOD    = 12.0;
  localparam int          RESET_CYCLES  = 8;
  localparam int          SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          IDLE_PERCENT  = 13;
  localparam int          RANDOM_PHASES = 7;
  localparam int          PHASE_ITEMS   = 40;
  localparam int          QUIET_PHASE   = 3;
  localparam int          HOLD_PHASE    = 4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata   = '0;   // [4:0] letter_code, [7:5] zero
  logic                  in_tlast   = 1'b0; // message_end
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [TDATA_W-1:0]    out_tdata;         // [4:0] cipher_code, [7:5] zero
  logic                  out_tlast;         // block_last
  logic                  out_tuser;         // message_last
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  bit                    idle_enable  = 1'b1;
  bit                    stall_enable = 1'b1;
  int unsigned           cycle_count  = 0;
  cipher_scoreboard      sb = new();

  hill_cipher_block_encrypt_unit #(
    .MAX_BLOCK (MAX_BLOCK)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2.0) clk = ~clk;
  end

  // Monitor: register writes and transfers on both streams, sampled at the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) sb.note_letter(in_tdata[LETTER_W-1:0], in_tlast);
      if (out_tvalid && out_tready) sb.check_cipher(out_tdata, out_tlast, out_tuser);
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= !(stall_enable && ($urandom_range(99) < IDLE_PERCENT));
  end

  // Watchdog on the run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one letter, with optional idle cycles first, and wait for its transfer.
  task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic msg_end);
    while (idle_enable && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(letter);
    in_tlast  <= msg_end;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the sender off until every cipher letter has arrived and the unit is quiet.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_count() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Load all key words, either random or with every entry at 31.
  task automatic load_key(input bit all_max);
    logic [CFG_DATA_W-1:0] value;
    for (int k = 0; k < PACK_COUNT; k++) begin
      value = all_max ? '1 : CFG_DATA_W'({$urandom, $urandom});
      write_reg(CFG_IDX_W'(REG_KEY_PACK_0 + k), value);
    end
  endtask

  // Block size in the low bits, random junk above.
  task automatic load_block_size(input logic [SIZE_W-1:0] size);
    logic [CFG_DATA_W-1:0] value;
    value = CFG_DATA_W'({$urandom, $urandom});
    value[SIZE_W-1:0] = size;
    write_reg(REG_BLOCK_SIZE, value);
  endtask

  function automatic logic [LETTER_W-1:0] random_letter();
    if ($urandom_range(99) < 10) return LETTER_W'($urandom_range(31, 26));
    return LETTER_W'($urandom_range(25, 0));
  endfunction

  // Main stimulus sequence.
  initial begin
    logic [LETTER_W-1:0] full_block [8];
    logic [SIZE_W-1:0]   size;

    full_block = '{5'd31, 5'd0, 5'd25, 5'd26, 5'd13, 5'd1, 5'd30, 5'd24};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: block size two and an all-zero key.
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd31, 1'b1);
    wait_for_drain();

    // Block size zero acts as one; an unknown register index is ignored.
    load_key(1'b0);
    load_block_size(4'd0);
    write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
    send_letter(5'd26, 1'b0);
    send_letter(5'd5, 1'b1);
    wait_for_drain();

    // Largest block with every key entry at 31, then a flush padded with seven X.
    load_key(1'b1);
    load_block_size(4'd8);
    foreach (full_block[k]) send_letter(full_block[k], 1'b0);
    send_letter(5'd3, 1'b1);
    wait_for_drain();

    // Sizes above eight act as eight; a message end on the first letter.
    load_key(1'b0);
    load_block_size(4'd15);
    send_letter(5'd1, 1'b1);
    // Part-filled block, then the size lowered below the fill level.
    send_letter(5'd7, 1'b0);
    send_letter(5'd16, 1'b0);
    send_letter(5'd29, 1'b0);
    send_letter(5'd2, 1'b0);
    wait_for_drain();
    load_block_size(4'd3);
    send_letter(5'd9, 1'b0);
    wait_for_drain();

    // Random phases, each with its own block size and key.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) size = 4'd1;
      else if (phase == 1) size = 4'd8;
      else size = SIZE_W'($urandom_range(15, 0));
      load_key($urandom_range(5) == 0);
      load_block_size(size);
      write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
      idle_enable  = (phase != QUIET_PHASE);
      stall_enable = (phase != QUIET_PHASE);
      for (int item = 0; item < PHASE_ITEMS; item++) begin
        if (phase == HOLD_PHASE && item == PHASE_ITEMS / 2) wait_for_drain();
        send_letter(random_letter(), $urandom_range(11) == 0);
      end
      wait_for_drain();
    end

    if (sb.errors == 0 && sb.expected_count() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
